### sv/grey_window_level_mapper_core_assert.svh
// Assertion macros shared by the mapper RTL.
// GWLM_ASSERT checks a property on the rising clock edge while reset is released.
// GWLM_ASSERT_ALWAYS checks a property on every rising clock edge, reset included.
`ifndef GREY_WINDOW_LEVEL_MAPPER_CORE_ASSERT_SVH
`define GREY_WINDOW_LEVEL_MAPPER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define GWLM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define GWLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GWLM_ASSERT(lbl, clk, rstn, prop, msg)
`define GWLM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/gwlm_pkg.sv
package gwlm_pkg;

  // Default parameter values.
  localparam int unsigned FRAME_PIXELS_DEF = 65536;
  localparam int unsigned SAMPLE_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned WWIDTH_W  = 31;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned GREY_W    = 8;
  localparam int unsigned IDX_LIM_W = 25;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned REG_W   = 2;

  localparam logic [REG_W-1:0] REG_MAP_MODE     = 2'd0;
  localparam logic [REG_W-1:0] REG_WINDOW_START = 2'd1;
  localparam logic [REG_W-1:0] REG_WINDOW_WIDTH = 2'd2;

  // Input item and mode codes.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_READ    = 1'b1;
  localparam logic MODE_AUTO   = 1'b0;
  localparam logic MODE_WINDOW = 1'b1;

  // Reset values.
  localparam logic signed [SAMPLE_W-1:0] RST_MIN    = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] RST_MAX    = 32'sh8000_0000;
  localparam logic        [WWIDTH_W-1:0] RST_WWIDTH = 31'd65536;

  // Divider widths: quotient bits produced one per step.
  localparam int unsigned DIV_W = SAMPLE_W;
  localparam int unsigned REM_W = DIV_W + GREY_W;
  localparam int unsigned CNT_W = $clog2(GREY_W);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/grey_window_level_mapper_core.sv
// Window/level grey-scale mapper for a stored frame of signed Q16.16 samples.
//
// Input channel: an item is taken at a rising edge with start high and busy low.
// A load item (action_i low) writes sample_i into the frame at pixel_index_i and
// updates the running minimum and maximum; frame_start_i restarts them at this
// sample. A load never raises busy. Loads past the frame end are dropped.
// A read item (action_i high) returns one beat on the result channel: valid_o is
// high for exactly one cycle with grey_value_o and read_index_o. The receiver
// cannot stall, so the beat is taken in that cycle. When the divider runs, a read
// passes through frame read, operand setup, one times-255 pass and eight
// restoring quotient steps of the shared subtractor, then the output register;
// it skips the divider when the span is empty or the pixel is on or beyond an
// edge. The next item is accepted in the result cycle.
// Configuration goes over the APB port at addresses 0, 4 and 8 (map mode, window
// start, window width); the user must write it only while idle; the block does not check.
// Reset clears the registers to auto mode, window 0..1.0, and an empty min/max
// range. The frame memory is not cleared: read only pixels that have been loaded.
module grey_window_level_mapper_core #(
  parameter int unsigned FRAME_PIXELS = gwlm_pkg::FRAME_PIXELS_DEF,
  parameter int unsigned SAMPLE_BITS  = gwlm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gwlm_pkg::PADDR_W-1:0]        paddr,
  input  logic [gwlm_pkg::PDATA_W-1:0]        pwdata,
  output logic [gwlm_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // Command channel.
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic signed [gwlm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [gwlm_pkg::IDX_W-1:0]          pixel_index_i,
  input  logic                                frame_start_i,
  // Result channel.
  output logic                                valid_o,
  output logic [gwlm_pkg::GREY_W-1:0]         grey_value_o,
  output logic [gwlm_pkg::IDX_W-1:0]          read_index_o
);

  `include "grey_window_level_mapper_core_assert.svh"

  localparam int unsigned SampleW = gwlm_pkg::SAMPLE_W;
  localparam int unsigned WwW     = gwlm_pkg::WWIDTH_W;
  localparam int unsigned IdxW    = gwlm_pkg::IDX_W;
  localparam int unsigned GreyW   = gwlm_pkg::GREY_W;
  localparam int unsigned DivW    = gwlm_pkg::DIV_W;
  localparam int unsigned LimW    = gwlm_pkg::IDX_LIM_W;
  localparam int unsigned PDataW  = gwlm_pkg::PDATA_W;
  localparam int unsigned RegW    = gwlm_pkg::REG_W;
  // Stored sample width: the loaded sample is sign-extended from its low bits.
  localparam int unsigned SbEff   = (SAMPLE_BITS >= SampleW) ? SampleW : SAMPLE_BITS;
  localparam int unsigned ExtSh   = SampleW - SbEff;
  localparam int unsigned AddrW   = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam logic [LimW-1:0] FrameLim = LimW'(FRAME_PIXELS);
  localparam logic [LimW-1:0] LastIdx  = LimW'(FRAME_PIXELS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_DIVW = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic                       valid_q, valid_d;
  logic [GreyW-1:0]           grey_q, grey_d;
  logic [IdxW-1:0]            ridx_q, ridx_d;
  logic signed [SampleW-1:0]  min_q, min_d;
  logic signed [SampleW-1:0]  max_q, max_d;
  logic                       mode_q, mode_d;
  logic signed [SampleW-1:0]  ws_q, ws_d;
  logic [WwW-1:0]             ww_q, ww_d;

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so every access completes in
  // its access phase.
  // ---------------------------------------------------------------------------
  logic            cfg_we;
  logic [RegW-1:0] cfg_reg;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_reg = paddr[RegW+1:2];

  always_comb begin
    mode_d = mode_q;
    ws_d   = ws_q;
    ww_d   = ww_q;
    if (cfg_we) begin
      unique case (cfg_reg)
        gwlm_pkg::REG_MAP_MODE:     mode_d = pwdata[0];
        gwlm_pkg::REG_WINDOW_START: ws_d   = $signed(pwdata[SampleW-1:0]);
        gwlm_pkg::REG_WINDOW_WIDTH: ww_d   = pwdata[WwW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      gwlm_pkg::REG_MAP_MODE:     prdata = PDataW'(mode_q);
      gwlm_pkg::REG_WINDOW_START: prdata = PDataW'(ws_q);
      gwlm_pkg::REG_WINDOW_WIDTH: prdata = PDataW'(ww_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Command decode and frame memory. The single memory port takes the write of
  // a load and the address of a read at the accepting edge; read data arrives
  // in the following cycle.
  // ---------------------------------------------------------------------------
  logic                      accept;
  logic [LimW-1:0]           idx_ext;
  logic                      idx_oob;
  logic [LimW-1:0]           idx_clamped;
  logic                      load_we;
  logic signed [SampleW-1:0] smp_shl, smp_ext;
  logic [SbEff-1:0]          ram_rdata;

  assign accept      = start && !busy;
  assign idx_ext     = LimW'(pixel_index_i);
  assign idx_oob     = (idx_ext >= FrameLim);
  // A read past the frame end reads the last entry and reports that position.
  assign idx_clamped = idx_oob ? LastIdx : idx_ext;
  assign load_we     = accept && (action_i == gwlm_pkg::ACT_LOAD) && !idx_oob;

  assign smp_shl = sample_i <<< ExtSh;
  assign smp_ext = smp_shl >>> ExtSh;

  gwlm_ram #(
    .WIDTH (SbEff),
    .DEPTH (FRAME_PIXELS)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .addr_i  (idx_clamped[AddrW-1:0]),
    .wdata_i (sample_i[SbEff-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Operand setup. Both modes reduce to floor(num * 255 / den): empty span or a
  // pixel at or below the lower edge gives 0, a pixel at or above the upper edge
  // gives 255, and everything else goes through the divider with num < den.
  // ---------------------------------------------------------------------------
  logic signed [SampleW-1:0] rd_shl, pix;
  logic signed [SampleW:0]   num_s, den_s;
  logic                      res_zero, res_sat;

  assign rd_shl = SampleW'(ram_rdata) << ExtSh;
  assign pix    = rd_shl >>> ExtSh;

  always_comb begin
    if (mode_q == gwlm_pkg::MODE_WINDOW) begin
      num_s = {pix[SampleW-1], pix} - {ws_q[SampleW-1], ws_q};
      den_s = {2'b00, ww_q};
    end else begin
      num_s = {pix[SampleW-1], pix} - {min_q[SampleW-1], min_q};
      den_s = {max_q[SampleW-1], max_q} - {min_q[SampleW-1], min_q};
    end
    res_zero = den_s[SampleW] || (den_s == '0) || num_s[SampleW] || (num_s == '0);
    res_sat  = (num_s >= den_s);
  end

  // Shared divider: one subtractor stepped by a small sequencer.
  logic                div_start;
  logic [GreyW-1:0]    div_quot;
  gwlm_pkg::div_stat_t div_stat;

  gwlm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_s[DivW-1:0]),
    .den_i   (den_s[DivW-1:0]),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and running min/max.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    valid_d   = 1'b0;
    grey_d    = grey_q;
    ridx_d    = ridx_q;
    min_d     = min_q;
    max_d     = max_q;
    div_start = 1'b0;

    if (load_we) begin
      if (frame_start_i) begin
        min_d = smp_ext;
        max_d = smp_ext;
      end else begin
        if (smp_ext < min_q) begin
          min_d = smp_ext;
        end
        if (smp_ext > max_q) begin
          max_d = smp_ext;
        end
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept && (action_i == gwlm_pkg::ACT_READ)) begin
          ridx_d  = idx_clamped[IdxW-1:0];
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        priority if (res_zero) begin
          grey_d  = '0;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else if (res_sat) begin
          grey_d  = '1;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_stat.done) begin
          grey_d  = div_quot;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      min_q   <= gwlm_pkg::RST_MIN;
      max_q   <= gwlm_pkg::RST_MAX;
      mode_q  <= gwlm_pkg::MODE_AUTO;
      ws_q    <= '0;
      ww_q    <= gwlm_pkg::RST_WWIDTH;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      min_q   <= min_d;
      max_q   <= max_d;
      mode_q  <= mode_d;
      ws_q    <= ws_d;
      ww_q    <= ww_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grey_q <= grey_d;
    ridx_q <= ridx_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign valid_o      = valid_q;
  assign grey_value_o = grey_q;
  assign read_index_o = ridx_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `GWLM_ASSERT(a_read_goes_busy, clk_i, rst_ni, (accept && (action_i == gwlm_pkg::ACT_READ)) |=> busy, "read not started")
  `GWLM_ASSERT(a_load_stays_idle, clk_i, rst_ni, (accept && (action_i == gwlm_pkg::ACT_LOAD)) |=> !busy, "load left block busy")
  `GWLM_ASSERT(a_result_after_busy, clk_i, rst_ni, valid_o |-> (!busy && $past(busy)), "result beat outside a read")
  `GWLM_ASSERT(a_div_done_waited, clk_i, rst_ni, div_stat.done |-> (state_q == S_DIVW), "divider result not awaited")
  `GWLM_ASSERT(a_div_busy_in_wait, clk_i, rst_ni, div_stat.busy |-> (state_q == S_DIVW), "divider running outside a read")
  `GWLM_ASSERT(a_minmax_order, clk_i, rst_ni, ((min_q <= max_q) || ((min_q == gwlm_pkg::RST_MIN) && (max_q == gwlm_pkg::RST_MAX))), "running min above max")

endmodule

### sv/gwlm_ram.sv
module gwlm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/gwlm_div.sv
module gwlm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [gwlm_pkg::DIV_W-1:0]     num_i,
  input  logic [gwlm_pkg::DIV_W-1:0]     den_i,
  output logic [gwlm_pkg::GREY_W-1:0]    quot_o,
  output gwlm_pkg::div_stat_t            stat_o
);

  localparam int unsigned DivW  = gwlm_pkg::DIV_W;
  localparam int unsigned RemW  = gwlm_pkg::REM_W;
  localparam int unsigned QW    = gwlm_pkg::GREY_W;
  localparam int unsigned CntW  = gwlm_pkg::CNT_W;
  localparam logic [CntW-1:0] StepLast = CntW'(QW - 1);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_STEP = 3'b100
  } dstate_e;

  dstate_e         state_q, state_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [RemW-1:0] dvs_q, dvs_d;
  logic [QW-1:0]   quot_q, quot_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;

  // One subtractor serves both the times-255 pass and the quotient steps.
  logic [RemW-1:0] op_a, op_b;
  logic [RemW:0]   diff;

  always_comb begin
    if (state_q == D_MUL) begin
      op_a = {rem_q[DivW-1:0], QW'(0)};
      op_b = rem_q;
    end else begin
      op_a = rem_q;
      op_b = dvs_q;
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          rem_d   = RemW'(num_i);
          dvs_d   = {1'b0, den_i, (QW - 1)'(0)};
          cnt_d   = StepLast;
          state_d = D_MUL;
        end
      end
      D_MUL: begin
        rem_d   = diff[RemW-1:0];
        state_d = D_STEP;
      end
      D_STEP: begin
        if (!diff[RemW]) begin
          rem_d = diff[RemW-1:0];
        end
        quot_d = {quot_q[QW-2:0], ~diff[RemW]};
        dvs_d  = dvs_q >> 1;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = (state_q != D_IDLE);
  assign stat_o.done = done_q;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

// Checks the grey-level mapper through its command and result channels.
// Commands are queued by the stimulus process and played out by a bursty
// driver; every read is predicted when it is accepted, and each result beat
// is matched against the oldest prediction.
module testbench;
  import gwlm_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;
  // Cycles to let pass after the last result before touching the registers.
  localparam int unsigned SETTLE_CYCLES = 14;

  typedef struct packed {
    logic               act;
    logic [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]   idx;
    logic               first;
    logic               drain_first;
  } frame_op_t;

  typedef struct packed {
    logic [GREY_W-1:0] grey;
    logic [IDX_W-1:0]  idx;
  } grey_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic                start = 1'b0;
  logic                busy;
  logic                action_i = ACT_LOAD;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic [IDX_W-1:0]    pixel_index_i = '0;
  logic                frame_start_i = 1'b0;

  logic                valid_o;
  logic [GREY_W-1:0]   grey_value_o;
  logic [IDX_W-1:0]    read_index_o;

  grey_window_level_mapper_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .sample_i      (sample_i),
    .pixel_index_i (pixel_index_i),
    .frame_start_i (frame_start_i),
    .valid_o       (valid_o),
    .grey_value_o  (grey_value_o),
    .read_index_o  (read_index_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mirror of the block's state, advanced as commands are accepted.
  int              frame_mirror [0:65535];
  int              run_min = 32'sh7FFF_FFFF;
  int              run_max = 32'sh8000_0000;
  logic            map_mode_m = MODE_AUTO;
  int              win_start = 0;
  logic [WWIDTH_W-1:0] win_width = RST_WWIDTH;

  frame_op_t  frame_ops_q[$];
  grey_beat_t expected_grey_q[$];

  // Stimulus-side bookkeeping: which pixels hold a sample, so that reads only
  // ever target loaded entries.
  bit         loaded_map [0:65535];
  int         loaded_list[$];

  frame_op_t  cur_op;
  grey_beat_t next_beat;
  grey_beat_t want;
  int         gap_left = 0;
  int         burst_left = 1;
  int         loads_taken = 0;
  int         reads_taken = 0;
  int         beats_checked = 0;
  int         reg_writes = 0;
  int         errors = 0;

  // Integer form of floor(num * 255 / den) with saturation; an empty span or a
  // value at or below the low edge maps to black.
  function automatic logic [GREY_W-1:0] scale_to_grey(input longint num, input longint den);
    longint q;
    if (den <= 0 || num <= 0) return '0;
    q = (num * 255) / den;
    if (q > 255) q = 255;
    return q[GREY_W-1:0];
  endfunction

  function automatic logic [GREY_W-1:0] grey_of_pixel(input int x);
    longint w;
    longint d;
    if (map_mode_m == MODE_AUTO)
      return scale_to_grey(longint'(x) - longint'(run_min),
                           longint'(run_max) - longint'(run_min));
    w = longint'(win_width);
    d = longint'(x) - longint'(win_start);
    if (d < 0) d = 0;
    if (d > w) d = w;
    return scale_to_grey(d, w);
  endfunction

  // Driver. The sender works in bursts separated by random gaps. A command
  // marked drain_first is held back until every pending read has returned.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur_op.act == ACT_LOAD) begin
          loads_taken++;
          frame_mirror[cur_op.idx] = cur_op.sample;
          if (cur_op.first) begin
            run_min = cur_op.sample;
            run_max = cur_op.sample;
          end else begin
            if (int'(cur_op.sample) < run_min) run_min = cur_op.sample;
            if (int'(cur_op.sample) > run_max) run_max = cur_op.sample;
          end
        end else begin
          reads_taken++;
          next_beat.grey = grey_of_pixel(frame_mirror[cur_op.idx]);
          next_beat.idx  = cur_op.idx;
          expected_grey_q.push_back(next_beat);
        end
      end

      if (start && busy) begin
        // The beat is still waiting to be taken; hold everything.
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (frame_ops_q.size() != 0 &&
                   !(frame_ops_q[0].drain_first && expected_grey_q.size() != 0)) begin
        cur_op = frame_ops_q.pop_front();
        action_i      <= cur_op.act;
        sample_i      <= cur_op.sample;
        pixel_index_i <= cur_op.idx;
        frame_start_i <= cur_op.first;
        start         <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Now and then a long burst with no gap at all.
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
          gap_left   = $urandom_range(0, 15);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: the receiver cannot stall, so every strobed cycle is a beat.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_grey_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got grey %0d index %0d",
                 $time, grey_value_o, read_index_o);
        errors++;
      end else begin
        want = expected_grey_q.pop_front();
        if (grey_value_o !== want.grey) begin
          $display("%0t: grey_value mismatch, expected %0d, got %0d (pixel %0d)",
                   $time, want.grey, grey_value_o, want.idx);
          errors++;
        end
        if (read_index_o !== want.idx) begin
          $display("%0t: read_index mismatch, expected %0d, got %0d",
                   $time, want.idx, read_index_o);
          errors++;
        end
        beats_checked++;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || valid_o) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  task automatic push_op(input logic act, input logic [SAMPLE_W-1:0] smp,
                         input logic [IDX_W-1:0] idx, input logic first,
                         input logic drain_first);
    frame_op_t op;
    op.act = act;
    op.sample = smp;
    op.idx = idx;
    op.first = first;
    op.drain_first = drain_first;
    frame_ops_q.push_back(op);
    if (act == ACT_LOAD && !loaded_map[idx]) begin
      loaded_map[idx] = 1'b1;
      loaded_list.push_back(int'(idx));
    end
  endtask

  // Reads carry random filler in the fields that a read ignores.
  task automatic push_read(input logic [IDX_W-1:0] idx, input logic drain_first);
    push_op(ACT_READ, $urandom, idx, 1'($urandom_range(0, 1)), drain_first);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    longint span;
    longint v;
    case ($urandom_range(0, 5))
      0: begin
        // Around the display window, spilling past both edges.
        span = longint'(win_width) + 1;
        v = longint'(win_start) - span / 4 + longint'($urandom) % (span + span / 2 + 1);
        return v[SAMPLE_W-1:0];
      end
      1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [IDX_W-1:0] pick_loaded();
    return IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  // Mostly well-formed frames (restart, loads, reads mixed in) with some
  // stray single commands between them.
  task automatic random_ops(input int count);
    int target;
    int len;
    int k;
    target = frame_ops_q.size() + count;
    while (frame_ops_q.size() < target) begin
      if ($urandom_range(0, 4) != 0) begin
        push_op(ACT_LOAD, pick_sample(), pick_index(), 1'b1, $urandom_range(0, 25) == 0);
        len = $urandom_range(3, 14);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) < 6) push_op(ACT_LOAD, pick_sample(), pick_index(), 1'b0, 1'b0);
          else push_read(pick_loaded(), 1'b0);
        end
      end else if ($urandom_range(0, 1) == 0) begin
        push_read(pick_loaded(), 1'b0);
      end else begin
        push_op(ACT_LOAD, pick_sample(), pick_index(), 1'($urandom_range(0, 1)), 1'b0);
      end
    end
  endtask

  // Waits until every command is taken and every read has returned, then lets
  // the block settle before the registers may be touched.
  task automatic wait_idle();
    while (frame_ops_q.size() != 0 || start || expected_grey_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] regno, input logic [PDATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regno, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (regno)
      REG_MAP_MODE:     map_mode_m = value[0];
      REG_WINDOW_START: win_start = value;
      REG_WINDOW_WIDTH: win_width = value[WWIDTH_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input logic mode, input logic [PDATA_W-1:0] wstart,
                           input logic [WWIDTH_W-1:0] wwidth);
    wait_idle();
    write_reg(REG_MAP_MODE, {31'b0, mode});
    write_reg(REG_WINDOW_START, wstart);
    write_reg(REG_WINDOW_WIDTH, {1'b0, wwidth});
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, auto mode. A single restarting load gives an empty
    // span, then the full signed range, then a narrow frame that leaves the
    // older pixels below and above it.
    push_op(ACT_LOAD, 32'h1234_0000, 16'h0000, 1'b1, 1'b0);
    push_read(16'h0000, 1'b0);
    push_op(ACT_LOAD, 32'h8000_0000, 16'hFFFF, 1'b0, 1'b0);
    push_op(ACT_LOAD, 32'h7FFF_FFFF, 16'h5555, 1'b0, 1'b0);
    push_op(ACT_LOAD, 32'h0000_0000, 16'hAAAA, 1'b0, 1'b0);
    push_read(16'hFFFF, 1'b0);
    push_read(16'h5555, 1'b0);
    push_read(16'h0000, 1'b0);
    push_op(ACT_LOAD, 32'h0001_0000, 16'h0001, 1'b1, 1'b1);
    push_op(ACT_LOAD, 32'h0002_0000, 16'h0002, 1'b0, 1'b0);
    push_op(ACT_LOAD, 32'h0001_8000, 16'h0003, 1'b0, 1'b0);
    push_read(16'hFFFF, 1'b0);
    push_read(16'h5555, 1'b0);
    push_read(16'h0001, 1'b0);
    push_read(16'h0002, 1'b0);
    push_read(16'h0003, 1'b1);

    // Window mode: default window clamps on both sides, then a window that
    // holds the whole narrow frame, an empty window, and the widest one.
    configure(MODE_WINDOW, 32'h0000_0000, RST_WWIDTH);
    push_read(16'h0001, 1'b0);
    push_read(16'hFFFF, 1'b0);
    configure(MODE_WINDOW, 32'h0000_C000, 31'h0001_8000);
    push_read(16'h0001, 1'b0);
    push_read(16'h0003, 1'b0);
    push_read(16'h0002, 1'b0);
    configure(MODE_WINDOW, 32'h0000_C000, 31'd0);
    push_read(16'h0002, 1'b0);
    configure(MODE_WINDOW, 32'h8000_0000, 31'h7FFF_FFFF);
    push_read(16'h5555, 1'b0);
    push_read(16'hFFFF, 1'b0);
    push_read(16'h0000, 1'b0);

    configure(MODE_AUTO, $urandom, WWIDTH_W'($urandom));
    random_ops(150);
    configure(MODE_WINDOW, $urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
              WWIDTH_W'($urandom_range(1, 32'h0040_0000)));
    random_ops(120);
    configure(MODE_WINDOW, $urandom, 31'd0);
    random_ops(50);
    configure(MODE_WINDOW, 32'h8000_0000, 31'h7FFF_FFFF);
    random_ops(60);
    configure(MODE_WINDOW, $urandom, WWIDTH_W'($urandom_range(0, 32'h7FFF_FFFF)));
    random_ops(100);
    configure(MODE_WINDOW, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000, 31'd1);
    random_ops(50);
    configure(MODE_AUTO, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    random_ops(150);

    wait_idle();
    $display("Accepted %0d loads and %0d reads, checked %0d result beats.",
             loads_taken, reads_taken, beats_checked);
    $display("Register writes: %0d, covering auto mode and nine window settings.",
             reg_writes);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
